// ===== src/efcr_pkg.sv =====
// Shared codes, widths and palette tables for the elevation false-color ramp.
package efcr_pkg;

	localparam int DATA_W     = 32;
	localparam int LEVEL_W    = 8;
	localparam int BAND_W     = 3;
	localparam int KIND_W     = 2;
	localparam int PAL_W      = 2;
	localparam int ADDR_W     = 4;
	localparam int DIV_STEPS  = 8;
	localparam int DIV_STAGE0 = 8;
	localparam int NUM_STAGES = DIV_STAGE0 + DIV_STEPS + 1;

	localparam logic [BAND_W-1:0] BAND_LAST = 3'd5;

	localparam logic [KIND_W-1:0] KIND_RAMP   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NODATA = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FLOOD  = 2'd2;

	localparam logic [PAL_W-1:0] PAL_LAND       = 2'd0;
	localparam logic [PAL_W-1:0] PAL_GRAY       = 2'd1;
	localparam logic [PAL_W-1:0] PAL_BLUE       = 2'd2;
	localparam logic [PAL_W-1:0] PAL_BLUE_ALIAS = 2'd3;

	localparam logic [1:0] REG_RANGE_MIN = 2'd0;
	localparam logic [1:0] REG_RANGE_MAX = 2'd1;
	localparam logic [1:0] REG_NODATA    = 2'd2;
	localparam logic [1:0] REG_FLOOD     = 2'd3;

	localparam logic [DATA_W-1:0] RANGE_MIN_RST = 32'sd0;
	localparam logic [DATA_W-1:0] RANGE_MAX_RST = 32'sd256;
	localparam logic [DATA_W-1:0] NODATA_RST    = -32'sd2560000;
	localparam logic [DATA_W-1:0] FLOOD_RST     = -32'sd2559744;

	localparam logic [23:0] SEA_BLUE   = {8'd40, 8'd83, 8'd107};
	localparam logic [23:0] LIGHT_BLUE = {8'd154, 8'd209, 8'd212};

	// palette node colors as {r, g, b}
	function automatic logic [23:0] ramp_node(input logic [PAL_W-1:0] pal,
		input logic [BAND_W-1:0] node);
		logic [23:0] c;
		c = '0;
		case ({pal, node})
			{PAL_LAND, 3'd0}: c = {8'd241, 8'd255, 8'd231};
			{PAL_LAND, 3'd1}: c = {8'd191, 8'd234, 8'd188};
			{PAL_LAND, 3'd2}: c = {8'd143, 8'd214, 8'd148};
			{PAL_LAND, 3'd3}: c = {8'd108, 8'd174, 8'd117};
			{PAL_LAND, 3'd4}: c = {8'd139, 8'd148, 8'd116};
			{PAL_LAND, 3'd5}: c = {8'd76, 8'd76, 8'd71};
			{PAL_LAND, 3'd6}: c = {8'd48, 8'd54, 8'd51};
			{PAL_GRAY, 3'd0}: c = {8'd242, 8'd242, 8'd242};
			{PAL_GRAY, 3'd1}: c = {8'd186, 8'd186, 8'd186};
			{PAL_GRAY, 3'd2}: c = {8'd132, 8'd132, 8'd132};
			{PAL_GRAY, 3'd3}: c = {8'd89, 8'd89, 8'd89};
			{PAL_GRAY, 3'd4}: c = {8'd50, 8'd50, 8'd50};
			{PAL_GRAY, 3'd5}: c = {8'd30, 8'd30, 8'd30};
			{PAL_GRAY, 3'd6}: c = {8'd0, 8'd0, 8'd0};
			{PAL_BLUE, 3'd0}: c = {8'd0, 8'd0, 8'd128};
			{PAL_BLUE, 3'd1}: c = {8'd0, 8'd0, 8'd153};
			{PAL_BLUE, 3'd2}: c = {8'd0, 8'd0, 8'd179};
			{PAL_BLUE, 3'd3}: c = {8'd0, 8'd0, 8'd204};
			{PAL_BLUE, 3'd4}: c = {8'd0, 8'd0, 8'd230};
			{PAL_BLUE, 3'd5}: c = {8'd0, 8'd0, 8'd255};
			{PAL_BLUE, 3'd6}: c = {8'd154, 8'd209, 8'd212};
			default:          c = '0;
		endcase
		return c;
	endfunction

endpackage

// ===== src/elevation_false_color_ramp.sv =====
// Elevation to RGB false-color mapper: APB registers and a 17-stage pipeline.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------------
//  input    | in_valid/in_ready   | sample, palette
//  output   | out_valid/out_ready | red_level, green_level, blue_level, band_index,
//           |                     | special_kind
//  config   | APB psel/penable    | paddr, pwdata, prdata (4 registers)
//
// One item per cycle while out_ready is high; each result passes through all 17 registered stages.
// The 8-step restoring divide that rounds each channel fills stages s8 to s16.
// Reset clears all valid bits and loads the register reset values.
// Each stage advances when empty or when the next one moves, so bubbles
// fill while out_ready is low; in_ready drops only with every stage full.
module elevation_false_color_ramp
	import efcr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DATA_W-1:0] sample,
	input  logic [PAL_W-1:0]         palette,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [LEVEL_W-1:0]       red_level,
	output logic [LEVEL_W-1:0]       green_level,
	output logic [LEVEL_W-1:0]       blue_level,
	output logic [BAND_W-1:0]        band_index,
	output logic [KIND_W-1:0]        special_kind
);

	typedef enum logic [1:0] {MODE_LO, MODE_HI, MODE_MIX} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]               kind;
		logic [BAND_W-1:0]               band;
		mode_t                           mode;
		logic [2:0][LEVEL_W-1:0]         lo;
		logic [2:0][LEVEL_W-1:0]         hi;
		logic [2:0]                      sgn;
		logic [2:0][41:0]                rem;
		logic [2:0][LEVEL_W-1:0]         quo;
		logic [32:0]                     dvs;
	} dv_t;

	// ---------------- configuration registers
	logic signed [DATA_W-1:0] range_min_q, range_max_q, nodata_q, flood_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= RANGE_MIN_RST;
			range_max_q <= RANGE_MAX_RST;
			nodata_q    <= NODATA_RST;
			flood_q     <= FLOOD_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_RANGE_MIN: range_min_q <= pwdata;
				REG_RANGE_MAX: range_max_q <= pwdata;
				REG_NODATA:    nodata_q    <= pwdata;
				REG_FLOOD:     flood_q     <= pwdata;
				default:       range_min_q <= range_min_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RANGE_MIN: prdata = range_min_q;
			REG_RANGE_MAX: prdata = range_max_q;
			REG_NODATA:    prdata = nodata_q;
			REG_FLOOD:     prdata = flood_q;
			default:       prdata = '0;
		endcase
	end

	// ---------------- valid bits and stage enables
	logic [NUM_STAGES:1] vld_s;
	logic [NUM_STAGES:1] vld_in;
	logic [NUM_STAGES:1] en;

	assign vld_in = {vld_s[NUM_STAGES-1:1], in_valid};
	assign en[NUM_STAGES] = !vld_s[NUM_STAGES] || out_ready;

	for (genvar k = 1; k < NUM_STAGES; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	assign in_ready  = en[1];
	assign out_valid = vld_s[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (en[k]) vld_s[k] <= vld_in[k];
			end
		end
	end

	// ---------------- s1: specials, offset from lower bound, span
	logic [PAL_W-1:0]         pal_in;
	logic [KIND_W-1:0]        kind_in;
	logic signed [DATA_W-1:0] lo_bound;
	logic signed [32:0]       diff_in, span_in;

	logic [PAL_W-1:0]   pal_s1;
	logic [KIND_W-1:0]  kind_s1;
	logic signed [32:0] diff_s1, span_s1;

	always_comb begin
		pal_in = (palette == PAL_BLUE_ALIAS) ? PAL_BLUE : palette;
		if (pal_in != PAL_BLUE && sample == nodata_q)
			kind_in = KIND_NODATA;
		else if (pal_in == PAL_LAND && sample == flood_q)
			kind_in = KIND_FLOOD;
		else
			kind_in = KIND_RAMP;
		lo_bound = range_min_q[DATA_W-1] ? '0 : range_min_q;
		diff_in  = {sample[DATA_W-1], sample} - {1'b0, lo_bound};
		span_in  = {range_max_q[DATA_W-1], range_max_q} - {1'b0, lo_bound};
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pal_s1  <= pal_in;
			kind_s1 <= kind_in;
			diff_s1 <= diff_in;
			span_s1 <= span_in;
		end
	end

	// ---------------- s2: x = 6 * offset, span multiples
	logic signed [35:0] dx, sx;
	logic [PAL_W-1:0]   pal_s2;
	logic [KIND_W-1:0]  kind_s2;
	logic signed [35:0] x_s2;
	logic signed [35:0] mul_s2 [0:5];

	assign dx = 36'(diff_s1);
	assign sx = 36'(span_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pal_s2    <= pal_s1;
			kind_s2   <= kind_s1;
			x_s2      <= (dx <<< 2) + (dx <<< 1);
			mul_s2[0] <= '0;
			mul_s2[1] <= sx;
			mul_s2[2] <= sx <<< 1;
			mul_s2[3] <= (sx <<< 1) + sx;
			mul_s2[4] <= sx <<< 2;
			mul_s2[5] <= (sx <<< 2) + sx;
		end
	end

	// ---------------- s3: band select
	logic [BAND_W-1:0]  band_c;
	logic [PAL_W-1:0]   pal_s3;
	logic [KIND_W-1:0]  kind_s3;
	logic [BAND_W-1:0]  band_s3;
	logic signed [35:0] x_s3;
	logic signed [35:0] mul_s3 [0:5];

	always_comb begin
		band_c = BAND_LAST;
		for (int k = 5; k >= 1; k--) begin
			if (x_s2 < mul_s2[k]) band_c = BAND_W'(k - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pal_s3  <= pal_s2;
			kind_s3 <= kind_s2;
			band_s3 <= band_c;
			x_s3    <= x_s2;
			mul_s3  <= mul_s2;
		end
	end

	// ---------------- s4: numerator relative to band start
	logic [PAL_W-1:0]   pal_s4;
	logic [KIND_W-1:0]  kind_s4;
	logic [BAND_W-1:0]  band_s4;
	logic signed [36:0] nr_s4;
	logic signed [32:0] span_s4;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pal_s4  <= pal_s3;
			kind_s4 <= kind_s3;
			band_s4 <= band_s3;
			nr_s4   <= 37'(x_s3) - 37'(mul_s3[band_s3]);
			span_s4 <= 33'(mul_s3[1]);
		end
	end

	// ---------------- s5: clamp decision, magnitudes of n and d
	mode_t              mode_c;
	logic signed [36:0] span_x, nr_neg;
	logic signed [32:0] span_neg;
	logic [31:0]        nn_c, dd_c;

	logic [PAL_W-1:0]  pal_s5;
	logic [KIND_W-1:0] kind_s5;
	logic [BAND_W-1:0] band_s5;
	mode_t             mode_s5;
	logic [31:0]       nn_s5, dd_s5;

	always_comb begin
		span_x   = 37'(span_s4);
		nr_neg   = -nr_s4;
		span_neg = -span_s4;
		nn_c     = nr_s4[31:0];
		dd_c     = span_s4[31:0];
		if (span_s4 == '0) begin
			mode_c = (nr_s4 > 0) ? MODE_HI : MODE_LO;
		end else if (!span_s4[32]) begin
			if (nr_s4 <= 0)           mode_c = MODE_LO;
			else if (nr_s4 >= span_x) mode_c = MODE_HI;
			else                      mode_c = MODE_MIX;
		end else begin
			nn_c = nr_neg[31:0];
			dd_c = span_neg[31:0];
			if (nr_s4 >= 0)           mode_c = MODE_LO;
			else if (nr_s4 <= span_x) mode_c = MODE_HI;
			else                      mode_c = MODE_MIX;
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pal_s5  <= pal_s4;
			kind_s5 <= kind_s4;
			band_s5 <= band_s4;
			mode_s5 <= mode_c;
			nn_s5   <= nn_c;
			dd_s5   <= dd_c;
		end
	end

	// ---------------- s6: palette nodes, channel step magnitude and sign
	logic [23:0]             node_lo, node_hi;
	logic [2:0][LEVEL_W-1:0] lo_c, hi_c, mag_c;
	logic [2:0]              sgn_c;
	logic [2:0][LEVEL_W:0]   dif_c;

	logic [KIND_W-1:0]       kind_s6;
	logic [BAND_W-1:0]       band_s6;
	mode_t                   mode_s6;
	logic [31:0]             nn_s6, dd_s6;
	logic [2:0][LEVEL_W-1:0] lo_s6, hi_s6, mag_s6;
	logic [2:0]              sgn_s6;

	always_comb begin
		node_lo = ramp_node(pal_s5, band_s5);
		node_hi = ramp_node(pal_s5, band_s5 + 3'd1);
		lo_c = {node_lo[23:16], node_lo[15:8], node_lo[7:0]};
		hi_c = {node_hi[23:16], node_hi[15:8], node_hi[7:0]};
		for (int c = 0; c < 3; c++) begin
			dif_c[c] = {1'b0, hi_c[c]} - {1'b0, lo_c[c]};
			sgn_c[c] = dif_c[c][LEVEL_W];
			mag_c[c] = sgn_c[c] ? LEVEL_W'(-dif_c[c]) : dif_c[c][LEVEL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			kind_s6 <= kind_s5;
			band_s6 <= band_s5;
			mode_s6 <= mode_s5;
			nn_s6   <= nn_s5;
			dd_s6   <= dd_s5;
			lo_s6   <= lo_c;
			hi_s6   <= hi_c;
			mag_s6  <= mag_c;
			sgn_s6  <= sgn_c;
		end
	end

	// ---------------- s7: mag * n
	logic [KIND_W-1:0]       kind_s7;
	logic [BAND_W-1:0]       band_s7;
	mode_t                   mode_s7;
	logic [31:0]             dd_s7;
	logic [2:0][LEVEL_W-1:0] lo_s7, hi_s7;
	logic [2:0]              sgn_s7;
	logic [2:0][39:0]        prod_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			kind_s7 <= kind_s6;
			band_s7 <= band_s6;
			mode_s7 <= mode_s6;
			dd_s7   <= dd_s6;
			lo_s7   <= lo_s6;
			hi_s7   <= hi_s6;
			sgn_s7  <= sgn_s6;
			for (int c = 0; c < 3; c++) prod_s7[c] <= 40'(mag_s6[c]) * 40'(nn_s6);
		end
	end

	// ---------------- s8..s16: q = (2*mag*n + d) / (2*d), one quotient bit a stage
	dv_t dv_s [0:DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en[DIV_STAGE0]) begin
			dv_s[0].kind <= kind_s7;
			dv_s[0].band <= band_s7;
			dv_s[0].mode <= mode_s7;
			dv_s[0].lo   <= lo_s7;
			dv_s[0].hi   <= hi_s7;
			dv_s[0].sgn  <= sgn_s7;
			dv_s[0].quo  <= '0;
			dv_s[0].dvs  <= {dd_s7, 1'b0};
			for (int c = 0; c < 3; c++)
				dv_s[0].rem[c] <= {1'b0, prod_s7[c], 1'b0} + 42'(dd_s7);
		end
	end

	for (genvar i = 1; i <= DIV_STEPS; i++) begin : g_div
		logic [41:0] trial;
		dv_t         nxt;

		assign trial = 42'(dv_s[i-1].dvs) << (DIV_STEPS - i);

		always_comb begin
			nxt = dv_s[i-1];
			for (int c = 0; c < 3; c++) begin
				if (dv_s[i-1].rem[c] >= trial) begin
					nxt.rem[c]                = dv_s[i-1].rem[c] - trial;
					nxt.quo[c][DIV_STEPS - i] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[DIV_STAGE0 + i]) dv_s[i] <= nxt;
		end
	end

	// ---------------- s17: output register
	dv_t                     fin;
	logic [2:0][LEVEL_W-1:0] col_c;
	logic [LEVEL_W-1:0]      red_s17, green_s17, blue_s17;
	logic [BAND_W-1:0]       band_s17;
	logic [KIND_W-1:0]       kind_s17;

	assign fin = dv_s[DIV_STEPS];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			unique case (fin.mode)
				MODE_LO:  col_c[c] = fin.lo[c];
				MODE_HI:  col_c[c] = fin.hi[c];
				MODE_MIX: col_c[c] = fin.sgn[c] ? fin.lo[c] - fin.quo[c]
				                                : fin.lo[c] + fin.quo[c];
				default:  col_c[c] = fin.lo[c];
			endcase
		end
		if (fin.kind == KIND_NODATA)
			col_c = {SEA_BLUE[23:16], SEA_BLUE[15:8], SEA_BLUE[7:0]};
		else if (fin.kind == KIND_FLOOD)
			col_c = {LIGHT_BLUE[23:16], LIGHT_BLUE[15:8], LIGHT_BLUE[7:0]};
	end

	always_ff @(posedge clk) begin
		if (en[NUM_STAGES]) begin
			red_s17   <= col_c[2];
			green_s17 <= col_c[1];
			blue_s17  <= col_c[0];
			band_s17  <= (fin.kind == KIND_RAMP) ? fin.band : '0;
			kind_s17  <= fin.kind;
		end
	end

	assign red_level    = red_s17;
	assign green_level  = green_s17;
	assign blue_level   = blue_s17;
	assign band_index   = band_s17;
	assign special_kind = kind_s17;

`ifndef ASSERT_OFF
	a_special_band0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && special_kind != KIND_RAMP |-> band_index == '0)
		else $error("special item with nonzero band");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> band_index <= BAND_LAST)
		else $error("band out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_s)
		else $error("input stalled with an empty stage");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s[1])
		else $error("accepted item lost at first stage");
`endif

endmodule
